### rtl/jdm_pkg.sv
package jdm_pkg;

  localparam int AXIS_W          = 16;
  localparam int IN_AXES         = 6;
  localparam int BUTTON_BITS     = 16;
  localparam int NUM_AXES_DEF    = 6;
  localparam int NUM_BUTTONS_DEF = 16;

  localparam int FRAC_W   = 15;
  localparam int QUOT_W   = 16;
  localparam int DZ_NUM_W = 31;
  localparam int DZ_DEN_W = 16;
  localparam int SQ_IN_W  = 48;
  localparam int SQ_OUT_W = 24;
  localparam int DS_NUM_W = 39;
  localparam int PROD_W   = 31;

  localparam int IN_DATA_W  = 112;
  localparam int OUT_DATA_W = 56;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_AXIS_SELECT   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BUTTON_SELECT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DEAD_ZONE_X   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_DEAD_ZONE_Y   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_DEAD_ZONE_ROT = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_VX       = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_VY       = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_VROT     = 3'd7;

  localparam logic [8:0] AXIS_SELECT_RST = 9'd8;

  typedef struct packed {
    logic [AXIS_W-1:0] vel_x;
    logic [AXIS_W-1:0] vel_y;
    logic [AXIS_W-1:0] vel_rot;
    logic [2:0]        buttons;
  } result_t;

endpackage

### rtl/jdm_div_pipe.sv
module jdm_div_pipe #(
  parameter int NW = 31,
  parameter int DW = 16,
  parameter int QW = 16,
  parameter int SW = 1
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          en,
  input  logic          in_valid,
  input  logic [NW-1:0] in_num,
  input  logic [DW-1:0] in_den,
  input  logic [SW-1:0] in_side,
  output logic          out_valid,
  output logic [QW-1:0] out_quot,
  output logic [SW-1:0] out_side
);

  logic [QW:0]   v_r;
  logic [DW-1:0] rem_r  [QW+1];
  logic [DW-1:0] den_r  [QW+1];
  logic [QW-1:0] low_r  [QW+1];
  logic [QW-1:0] quot_r [QW+1];
  logic [SW-1:0] side_r [QW+1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r[0] <= 1'b0;
    end else if (en) begin
      v_r[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r[0]  <= DW'(in_num[NW-1:QW]);
      den_r[0]  <= in_den;
      low_r[0]  <= in_num[QW-1:0];
      quot_r[0] <= '0;
      side_r[0] <= in_side;
    end
  end

  for (genvar k = 0; k < QW; k++) begin : g_stage
    logic [DW:0] trial;
    logic [DW:0] diff;
    logic        ge;

    always_comb begin
      trial = {rem_r[k], low_r[k][QW-1-k]};
      diff  = trial - {1'b0, den_r[k]};
      ge    = ~diff[DW];
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[k+1] <= 1'b0;
      end else if (en) begin
        v_r[k+1] <= v_r[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k+1]  <= ge ? diff[DW-1:0] : trial[DW-1:0];
        den_r[k+1]  <= den_r[k];
        low_r[k+1]  <= low_r[k];
        quot_r[k+1] <= {quot_r[k][QW-2:0], ge};
        side_r[k+1] <= side_r[k];
      end
    end
  end

  assign out_valid = v_r[QW];
  assign out_quot  = quot_r[QW];
  assign out_side  = side_r[QW];

endmodule

### rtl/jdm_isqrt_pipe.sv
module jdm_isqrt_pipe #(
  parameter int IW = 48,
  parameter int QW = 24,
  parameter int SW = 1
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          en,
  input  logic          in_valid,
  input  logic [IW-1:0] in_val,
  input  logic [SW-1:0] in_side,
  output logic          out_valid,
  output logic [QW-1:0] out_root,
  output logic [SW-1:0] out_side
);

  localparam int RW = QW + 2;

  logic [QW:0]   v_r;
  logic [IW-1:0] val_r  [QW+1];
  logic [RW-1:0] rem_r  [QW+1];
  logic [QW-1:0] root_r [QW+1];
  logic [SW-1:0] side_r [QW+1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r[0] <= 1'b0;
    end else if (en) begin
      v_r[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      val_r[0]  <= in_val;
      rem_r[0]  <= '0;
      root_r[0] <= '0;
      side_r[0] <= in_side;
    end
  end

  for (genvar k = 0; k < QW; k++) begin : g_stage
    logic [RW-1:0] remn;
    logic [RW-1:0] trial;
    logic [RW:0]   diff;
    logic          ge;

    always_comb begin
      remn  = {rem_r[k][RW-3:0], val_r[k][2*(QW-1-k)+1 -: 2]};
      trial = {root_r[k], 2'b01};
      diff  = {1'b0, remn} - {1'b0, trial};
      ge    = ~diff[RW];
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[k+1] <= 1'b0;
      end else if (en) begin
        v_r[k+1] <= v_r[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        val_r[k+1]  <= val_r[k];
        rem_r[k+1]  <= ge ? diff[RW-1:0] : remn;
        root_r[k+1] <= {root_r[k][QW-2:0], ge};
        side_r[k+1] <= side_r[k];
      end
    end
  end

  assign out_valid = v_r[QW];
  assign out_root  = root_r[QW];
  assign out_side  = side_r[QW];

endmodule

### rtl/joystick_deadzone_disc_mapper_unit.sv
// Channel   Direction  Handshake             Payload
// in_       slave      in_tvalid/in_tready   in_tdata: axis_0..axis_5, button_word
// out_      master     out_tvalid/out_tready out_tdata: vel_x, vel_y, vel_rot, buttons
// cfg_      write      cfg_we                cfg_index, cfg_wdata
//
// One sample is taken per cycle while the skid register is empty. Samples
// pass the dead zone divider (17 stages), clamp and squaring stages, the
// square root (25 stages), the disc divider (17 stages) and the gain and
// output stages. Reset is synchronous and active low; it clears the valid
// bits and the configuration registers, but sets the axis select to 8.
// A stalled output holds the whole pipeline once the skid register is full.
module joystick_deadzone_disc_mapper_unit #(
  parameter int NUM_AXES    = jdm_pkg::NUM_AXES_DEF,
  parameter int NUM_BUTTONS = jdm_pkg::NUM_BUTTONS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  // axis_0 [15:0] .. axis_5 [95:80], button_word [111:96]
  input  logic [jdm_pkg::IN_DATA_W-1:0]   in_tdata,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // vel_x [15:0], vel_y [31:16], vel_rot [47:32], kick [48], activate [49],
  // deactivate [50], zero [55:51]
  output logic [jdm_pkg::OUT_DATA_W-1:0]  out_tdata,
  input  logic                            cfg_we,
  input  logic [jdm_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [jdm_pkg::CFG_DATA_W-1:0]  cfg_wdata
);

  localparam int AW = jdm_pkg::AXIS_W;
  localparam int QW = jdm_pkg::QUOT_W;
  localparam int FW = jdm_pkg::FRAC_W;

  logic [8:0]    axis_sel_r;
  logic [14:0]   btn_sel_r;
  logic [FW-1:0] dz_x_r, dz_y_r, dz_r_r;
  logic signed [AW-1:0] gain_x_r, gain_y_r, gain_r_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      axis_sel_r <= jdm_pkg::AXIS_SELECT_RST;
      btn_sel_r  <= '0;
      dz_x_r     <= '0;
      dz_y_r     <= '0;
      dz_r_r     <= '0;
      gain_x_r   <= '0;
      gain_y_r   <= '0;
      gain_r_r   <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        jdm_pkg::REG_AXIS_SELECT:   axis_sel_r <= cfg_wdata[8:0];
        jdm_pkg::REG_BUTTON_SELECT: btn_sel_r  <= cfg_wdata[14:0];
        jdm_pkg::REG_DEAD_ZONE_X:   dz_x_r     <= cfg_wdata[FW-1:0];
        jdm_pkg::REG_DEAD_ZONE_Y:   dz_y_r     <= cfg_wdata[FW-1:0];
        jdm_pkg::REG_DEAD_ZONE_ROT: dz_r_r     <= cfg_wdata[FW-1:0];
        jdm_pkg::REG_GAIN_VX:       gain_x_r   <= cfg_wdata;
        jdm_pkg::REG_GAIN_VY:       gain_y_r   <= cfg_wdata;
        jdm_pkg::REG_GAIN_VROT:     gain_r_r   <= cfg_wdata;
        default: ;
      endcase
    end
  end

  logic en;
  logic spare_v_r;
  assign en        = ~spare_v_r;
  assign in_tready = en;

  logic [AW-1:0] axes [8];
  logic [31:0]   btn_word;
  logic [2:0]    btn_pick;
  logic [AW-1:0] raw_x, raw_y, raw_r;

  function automatic logic [AW-1:0] pick_axis(input logic [AW-1:0] a, input logic [2:0] idx);
    logic ok;
    ok = (int'(idx) < NUM_AXES) && (int'(idx) < jdm_pkg::IN_AXES);
    return ok ? a : '0;
  endfunction

  function automatic logic pick_btn(input logic [31:0] w, input logic [4:0] idx);
    logic ok;
    ok = (int'(idx) < NUM_BUTTONS) && (int'(idx) < jdm_pkg::BUTTON_BITS);
    return ok & w[idx];
  endfunction

  always_comb begin
    for (int i = 0; i < 8; i++) begin
      axes[i] = '0;
    end
    for (int i = 0; i < jdm_pkg::IN_AXES; i++) begin
      axes[i] = in_tdata[i*AW +: AW];
    end
    btn_word = {16'b0, in_tdata[jdm_pkg::IN_AXES*AW +: jdm_pkg::BUTTON_BITS]};
    raw_x = pick_axis(axes[axis_sel_r[2:0]], axis_sel_r[2:0]);
    raw_y = pick_axis(axes[axis_sel_r[5:3]], axis_sel_r[5:3]);
    raw_r = pick_axis(axes[axis_sel_r[8:6]], axis_sel_r[8:6]);
    btn_pick[0] = pick_btn(btn_word, btn_sel_r[4:0]);
    btn_pick[1] = pick_btn(btn_word, btn_sel_r[9:5]);
    btn_pick[2] = pick_btn(btn_word, btn_sel_r[14:10]);
  end

  function automatic logic [jdm_pkg::DZ_NUM_W-1:0] dz_num(input logic [AW-1:0] a,
                                                         input logic [FW-1:0] d);
    logic [AW-1:0] m;
    logic [AW-1:0] diff;
    m    = a[AW-1] ? AW'(~a + 16'd1) : a;
    diff = m - {1'b0, d};
    return (m >= {1'b0, d}) ? {diff, {FW{1'b0}}} : '0;
  endfunction

  function automatic logic [AW-1:0] dz_den(input logic [FW-1:0] d);
    return 16'h8000 - {1'b0, d};
  endfunction

  logic          dzx_v;
  logic [QW-1:0] dzx_q, dzy_q, dzr_q;
  logic [3:0]    dzx_side;
  logic          dzy_side, dzr_side;

  jdm_div_pipe #(.NW(jdm_pkg::DZ_NUM_W), .DW(jdm_pkg::DZ_DEN_W), .QW(QW), .SW(4)) u_dz_x (
    .clk(clk), .rst_n(rst_n), .en(en), .in_valid(in_tvalid),
    .in_num(dz_num(raw_x, dz_x_r)), .in_den(dz_den(dz_x_r)),
    .in_side({btn_pick, raw_x[AW-1]}),
    .out_valid(dzx_v), .out_quot(dzx_q), .out_side(dzx_side)
  );

  jdm_div_pipe #(.NW(jdm_pkg::DZ_NUM_W), .DW(jdm_pkg::DZ_DEN_W), .QW(QW), .SW(1)) u_dz_y (
    .clk(clk), .rst_n(rst_n), .en(en), .in_valid(in_tvalid),
    .in_num(dz_num(raw_y, dz_y_r)), .in_den(dz_den(dz_y_r)), .in_side(raw_y[AW-1]),
    .out_valid(), .out_quot(dzy_q), .out_side(dzy_side)
  );

  jdm_div_pipe #(.NW(jdm_pkg::DZ_NUM_W), .DW(jdm_pkg::DZ_DEN_W), .QW(QW), .SW(1)) u_dz_r (
    .clk(clk), .rst_n(rst_n), .en(en), .in_valid(in_tvalid),
    .in_num(dz_num(raw_r, dz_r_r)), .in_den(dz_den(dz_r_r)), .in_side(raw_r[AW-1]),
    .out_valid(), .out_quot(dzr_q), .out_side(dzr_side)
  );

  // Magnitudes after clamping; a positive full deflection saturates.
  function automatic logic [QW-1:0] clamp_mag(input logic [QW-1:0] q, input logic neg);
    return (!neg && q[QW-1]) ? 16'h7FFF : q;
  endfunction

  logic          s1_v_r;
  logic [QW-1:0] ax_r, ay_r, ar_r, mx_r;
  logic          sx1_r, sy1_r, sr1_r;
  logic [2:0]    btn1_r;
  logic [QW-1:0] ax_nxt, ay_nxt;

  assign ax_nxt = clamp_mag(dzx_q, dzx_side[0]);
  assign ay_nxt = clamp_mag(dzy_q, dzy_side);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (en) begin
      s1_v_r <= dzx_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ax_r   <= ax_nxt;
      ay_r   <= ay_nxt;
      mx_r   <= (ax_nxt >= ay_nxt) ? ax_nxt : ay_nxt;
      ar_r   <= clamp_mag(dzr_q, dzr_side);
      sx1_r  <= dzx_side[0];
      sy1_r  <= dzy_side;
      sr1_r  <= dzr_side;
      btn1_r <= dzx_side[3:1];
    end
  end

  logic        s2_v_r;
  logic [31:0] sqx_r, sqy_r, px_r, py_r;
  logic [QW-1:0] ar2_r;
  logic        sx2_r, sy2_r, sr2_r;
  logic [2:0]  btn2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r <= 1'b0;
    end else if (en) begin
      s2_v_r <= s1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sqx_r  <= ax_r * ax_r;
      sqy_r  <= ay_r * ay_r;
      px_r   <= ax_r * mx_r;
      py_r   <= ay_r * mx_r;
      ar2_r  <= ar_r;
      sx2_r  <= sx1_r;
      sy2_r  <= sy1_r;
      sr2_r  <= sr1_r;
      btn2_r <= btn1_r;
    end
  end

  localparam int PW     = jdm_pkg::PROD_W;
  localparam int SQ_SW  = 2 * PW + 2 + QW + 1 + 3;

  logic [31:0]                   sum_sq;
  logic                          sq_v;
  logic [jdm_pkg::SQ_OUT_W-1:0]  sq_root;
  logic [SQ_SW-1:0]              sq_side;
  logic [jdm_pkg::SQ_OUT_W-1:0]  disc_den;

  assign sum_sq = sqx_r + sqy_r;

  jdm_isqrt_pipe #(.IW(jdm_pkg::SQ_IN_W), .QW(jdm_pkg::SQ_OUT_W), .SW(SQ_SW)) u_isqrt (
    .clk(clk), .rst_n(rst_n), .en(en), .in_valid(s2_v_r),
    .in_val({sum_sq, 16'b0}),
    .in_side({btn2_r, sr2_r, ar2_r, sy2_r, sx2_r, py_r[PW-1:0], px_r[PW-1:0]}),
    .out_valid(sq_v), .out_root(sq_root), .out_side(sq_side)
  );

  // An all-zero pair gives a zero numerator; the divisor is held nonzero.
  assign disc_den = (sq_root == '0) ? jdm_pkg::SQ_OUT_W'(1) : sq_root;

  localparam int DX_SW = 1 + QW + 1 + 3;

  logic             dx_v;
  logic [QW-1:0]    dx_q, dy_q;
  logic [DX_SW-1:0] dx_side;
  logic             dy_side;

  jdm_div_pipe #(.NW(jdm_pkg::DS_NUM_W), .DW(jdm_pkg::SQ_OUT_W), .QW(QW), .SW(DX_SW)) u_ds_x (
    .clk(clk), .rst_n(rst_n), .en(en), .in_valid(sq_v),
    .in_num({sq_side[PW-1:0], 8'b0}), .in_den(disc_den),
    .in_side({sq_side[SQ_SW-1:2*PW+2], sq_side[2*PW]}),
    .out_valid(dx_v), .out_quot(dx_q), .out_side(dx_side)
  );

  jdm_div_pipe #(.NW(jdm_pkg::DS_NUM_W), .DW(jdm_pkg::SQ_OUT_W), .QW(QW), .SW(1)) u_ds_y (
    .clk(clk), .rst_n(rst_n), .en(en), .in_valid(sq_v),
    .in_num({sq_side[2*PW-1:PW], 8'b0}), .in_den(disc_den),
    .in_side(sq_side[2*PW+1]),
    .out_valid(), .out_quot(dy_q), .out_side(dy_side)
  );

  // dx_side: sx [0], ar [16:1], sr [17], buttons [20:18]
  function automatic logic signed [AW-1:0] to_signed(input logic [QW-1:0] q, input logic neg);
    logic [QW-1:0] c;
    c = clamp_mag(q, neg);
    return neg ? AW'(~c + 16'd1) : c;
  endfunction

  logic                 s4_v_r;
  logic signed [AW-1:0] vx_r, vy_r, vr_r;
  logic [2:0]           btn4_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s4_v_r <= 1'b0;
    end else if (en) begin
      s4_v_r <= dx_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      vx_r   <= to_signed(dx_q, dx_side[0]);
      vy_r   <= to_signed(dy_q, dy_side);
      vr_r   <= to_signed(dx_side[QW:1], dx_side[QW+1]);
      btn4_r <= dx_side[QW+4:QW+2];
    end
  end

  logic                 s5_v_r;
  logic signed [31:0]   gx_r, gy_r, gr_r;
  logic [2:0]           btn5_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s5_v_r <= 1'b0;
    end else if (en) begin
      s5_v_r <= s4_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      gx_r   <= gain_x_r * vx_r;
      gy_r   <= gain_y_r * vy_r;
      gr_r   <= gain_r_r * vr_r;
      btn5_r <= btn4_r;
    end
  end

  // Scales by one full deflection, truncating toward zero, then saturates.
  function automatic logic [AW-1:0] scale_sat(input logic signed [31:0] p);
    logic signed [31:0] t;
    t = p[31] ? ((p + 32'sd32767) >>> FW) : (p >>> FW);
    return (t > 32'sd32767) ? 16'h7FFF : t[AW-1:0];
  endfunction

  logic              pipe_v_r;
  jdm_pkg::result_t  pipe_d_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pipe_v_r <= 1'b0;
    end else if (en) begin
      pipe_v_r <= s5_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pipe_d_r.vel_x   <= scale_sat(gx_r);
      pipe_d_r.vel_y   <= scale_sat(gy_r);
      pipe_d_r.vel_rot <= scale_sat(gr_r);
      pipe_d_r.buttons <= btn5_r;
    end
  end

  logic             out_v_r;
  jdm_pkg::result_t out_d_r, spare_d_r;
  logic             incoming;

  assign incoming = en & pipe_v_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r   <= 1'b0;
      spare_v_r <= 1'b0;
    end else if (!out_v_r || out_tready) begin
      if (spare_v_r) begin
        out_v_r   <= 1'b1;
        spare_v_r <= 1'b0;
      end else begin
        out_v_r <= incoming;
      end
    end else if (incoming) begin
      spare_v_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_v_r || out_tready) begin
      out_d_r <= spare_v_r ? spare_d_r : pipe_d_r;
    end else if (incoming) begin
      spare_d_r <= pipe_d_r;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = {5'b0, out_d_r.buttons[2], out_d_r.buttons[1], out_d_r.buttons[0],
                       out_d_r.vel_rot, out_d_r.vel_y, out_d_r.vel_x};

  a_spare_needs_out: assert property (@(posedge clk) disable iff (!rst_n)
    spare_v_r |-> out_v_r) else $error("skid register full while output empty");

  a_spare_fill: assert property (@(posedge clk) disable iff (!rst_n)
    (out_v_r && !out_tready && pipe_v_r && in_tready) |=> spare_v_r)
    else $error("stalled beat was not parked in the skid register");

  a_spare_drain: assert property (@(posedge clk) disable iff (!rst_n)
    (spare_v_r && out_tready) |=> (out_v_r && !spare_v_r))
    else $error("skid register did not drain into the output");

endmodule

### test/joystick_result_checker.sv
`timescale 1ns / 1ps

module joystick_result_checker (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  input  logic                          in_tready,
  input  logic [jdm_pkg::IN_DATA_W-1:0] in_tdata,
  input  logic                          out_tvalid,
  input  logic                          out_tready,
  input  logic [jdm_pkg::OUT_DATA_W-1:0] out_tdata,
  input  logic                          cfg_we,
  input  logic [jdm_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [jdm_pkg::CFG_DATA_W-1:0] cfg_wdata,
  output int                            fail_count,
  output int                            pending,
  output int                            results_seen
);
  import jdm_pkg::*;

  typedef struct {
    logic [15:0] vel_x;
    logic [15:0] vel_y;
    logic [15:0] vel_rot;
    logic        kick;
    logic        activate;
    logic        deactivate;
  } velocity_cmd_t;

  logic [8:0]         axis_sel;
  logic [14:0]        button_sel;
  logic [14:0]        dz_x, dz_y, dz_rot;
  logic signed [15:0] gain_x, gain_y, gain_rot;
  velocity_cmd_t      expected_cmds[$];

  initial begin
    fail_count = 0;
    pending = 0;
    results_seen = 0;
  end

  function automatic longint clamp16(longint v);
    if (v > 32767) return 32767;
    if (v < -32768) return -32768;
    return v;
  endfunction

  function automatic longint select_axis(logic [IN_DATA_W-1:0] d, logic [2:0] idx);
    if (idx >= NUM_AXES_DEF || idx >= IN_AXES) return 0;
    return longint'($signed(d[idx*16 +: 16]));
  endfunction

  function automatic logic select_button(logic [IN_DATA_W-1:0] d, logic [4:0] idx);
    if (idx >= NUM_BUTTONS_DEF || idx >= BUTTON_BITS) return 1'b0;
    return d[96 + idx];
  endfunction

  function automatic longint apply_dead_zone(longint a, logic [14:0] thr);
    longint mag;
    longint t;
    longint r;
    mag = (a < 0) ? -a : a;
    t = thr;
    if (mag < t) return 0;
    r = ((mag - t) << 15) / (32768 - t);
    return clamp16((a < 0) ? -r : r);
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned res;
    longint unsigned b;
    res = 0;
    b = 64'h1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v = v - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  function automatic longint disc_coord(longint c, longint unsigned mx, longint unsigned q);
    longint unsigned mag;
    longint r;
    mag = (c < 0) ? -c : c;
    r = longint'((mag * mx * 256) / q);
    return clamp16((c < 0) ? -r : r);
  endfunction

  function automatic longint scale_gain(logic signed [15:0] g, longint v);
    longint p;
    p = longint'(g) * v;
    return clamp16(p / 32768);
  endfunction

  function automatic velocity_cmd_t predict_command(logic [IN_DATA_W-1:0] d);
    velocity_cmd_t c;
    longint x, y, r;
    longint unsigned ax, ay, mx, s, q;
    x = apply_dead_zone(select_axis(d, axis_sel[2:0]), dz_x);
    y = apply_dead_zone(select_axis(d, axis_sel[5:3]), dz_y);
    r = apply_dead_zone(select_axis(d, axis_sel[8:6]), dz_rot);
    ax = (x < 0) ? -x : x;
    ay = (y < 0) ? -y : y;
    s = ax * ax + ay * ay;
    if (s != 0) begin
      q = int_sqrt(s << 16);
      mx = (ax >= ay) ? ax : ay;
      x = disc_coord(x, mx, q);
      y = disc_coord(y, mx, q);
    end
    c.vel_x = 16'(scale_gain(gain_x, x));
    c.vel_y = 16'(scale_gain(gain_y, y));
    c.vel_rot = 16'(scale_gain(gain_rot, r));
    c.kick = select_button(d, button_sel[4:0]);
    c.activate = select_button(d, button_sel[9:5]);
    c.deactivate = select_button(d, button_sel[14:10]);
    return c;
  endfunction

  task automatic report(string what, logic [15:0] got, logic [15:0] want);
    $display("mismatch on %s: got %h, expected %h", what, got, want);
    fail_count++;
  endtask

  always @(posedge clk) begin
    velocity_cmd_t w;
    if (!rst_n) begin
      axis_sel <= AXIS_SELECT_RST;
      button_sel <= '0;
      dz_x <= '0;
      dz_y <= '0;
      dz_rot <= '0;
      gain_x <= '0;
      gain_y <= '0;
      gain_rot <= '0;
    end else begin
      if (in_tvalid && in_tready) begin
        expected_cmds.push_back(predict_command(in_tdata));
      end
      if (out_tvalid && out_tready) begin
        results_seen++;
        if (expected_cmds.size() == 0) begin
          report("unexpected beat", out_tdata[15:0], 16'h0);
        end else begin
          w = expected_cmds.pop_front();
          if (out_tdata[15:0] !== w.vel_x) report("vel_x", out_tdata[15:0], w.vel_x);
          if (out_tdata[31:16] !== w.vel_y) report("vel_y", out_tdata[31:16], w.vel_y);
          if (out_tdata[47:32] !== w.vel_rot) report("vel_rot", out_tdata[47:32], w.vel_rot);
          if (out_tdata[48] !== w.kick) report("kick", 16'(out_tdata[48]), 16'(w.kick));
          if (out_tdata[49] !== w.activate)
            report("activate", 16'(out_tdata[49]), 16'(w.activate));
          if (out_tdata[50] !== w.deactivate)
            report("deactivate", 16'(out_tdata[50]), 16'(w.deactivate));
          if (out_tdata[55:51] !== 5'd0) report("padding", 16'(out_tdata[55:51]), 16'h0);
        end
      end
      if (cfg_we) begin
        case (cfg_index)
          REG_AXIS_SELECT:   axis_sel <= cfg_wdata[8:0];
          REG_BUTTON_SELECT: button_sel <= cfg_wdata[14:0];
          REG_DEAD_ZONE_X:   dz_x <= cfg_wdata[14:0];
          REG_DEAD_ZONE_Y:   dz_y <= cfg_wdata[14:0];
          REG_DEAD_ZONE_ROT: dz_rot <= cfg_wdata[14:0];
          REG_GAIN_VX:       gain_x <= cfg_wdata;
          REG_GAIN_VY:       gain_y <= cfg_wdata;
          REG_GAIN_VROT:     gain_rot <= cfg_wdata;
          default: ;
        endcase
      end
      pending = expected_cmds.size();
    end
  end
endmodule

### test/joystick_deadzone_disc_mapper_unit_tb.sv
`timescale 1ns / 1ps

module joystick_deadzone_disc_mapper_unit_tb;
  import jdm_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int DRAIN_CYCLES = 70;

  logic                   clk;
  logic                   rst_n;
  logic                   in_tvalid;
  logic                   in_tready;
  logic [IN_DATA_W-1:0]   in_tdata;
  logic                   out_tvalid;
  logic                   out_tready;
  logic [OUT_DATA_W-1:0]  out_tdata;
  logic                   cfg_we;
  logic [CFG_IDX_W-1:0]   cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_wdata;
  int                     fail_count;
  int                     pending;
  int                     results_seen;
  int                     cycles;
  int                     idle_pct;
  int                     stall_pct;
  logic [15:0]            cur_dz;

  joystick_deadzone_disc_mapper_unit dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  joystick_result_checker u_checker (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
    .fail_count(fail_count), .pending(pending), .results_seen(results_seen)
  );

  always begin
    clk = 1'b1;
    #10;
    clk = 1'b0;
    #10;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycles, pending);
      $display("CHECKS FAILED");
      $finish;
    end
  end

  always @(negedge clk) begin
    out_tready <= ($urandom_range(99) >= stall_pct);
  end

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [15:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic send_sample(logic [IN_DATA_W-1:0] d);
    @(negedge clk);
    while ($urandom_range(99) < idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= d;
    do @(posedge clk); while (!in_tready);
  endtask

  task automatic drain();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  function automatic logic [15:0] rand_axis();
    case ($urandom_range(9))
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return 16'h0000;
      3: return 16'(cur_dz + $urandom_range(4)) ^ ($urandom_range(1) ? 16'hffff : 16'h0);
      4: return 16'(cur_dz - 1);
      5: return 16'(-int'(cur_dz));
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [IN_DATA_W-1:0] rand_sample();
    logic [IN_DATA_W-1:0] d;
    for (int i = 0; i < 6; i++) d[i*16 +: 16] = rand_axis();
    d[111:96] = 16'($urandom);
    return d;
  endfunction

  function automatic logic [15:0] rand_extreme(logic [15:0] lo, logic [15:0] hi, int mask_w);
    case ($urandom_range(5))
      0: return lo;
      1: return hi;
      default: return 16'($urandom) & 16'((32'h1 << mask_w) - 1);
    endcase
  endfunction

  task automatic random_setting();
    logic [15:0] dz;
    write_reg(REG_AXIS_SELECT, 16'($urandom_range(511)));
    write_reg(REG_BUTTON_SELECT, 16'($urandom_range(32767)));
    dz = rand_extreme(16'h0, 16'h7fff, 15);
    cur_dz = dz;
    write_reg(REG_DEAD_ZONE_X, dz);
    write_reg(REG_DEAD_ZONE_Y, rand_extreme(16'h0, 16'h7fff, 15));
    write_reg(REG_DEAD_ZONE_ROT, rand_extreme(16'h0, 16'h7fff, 15));
    write_reg(REG_GAIN_VX, rand_extreme(16'h8000, 16'h7fff, 16));
    write_reg(REG_GAIN_VY, rand_extreme(16'h8000, 16'h7fff, 16));
    write_reg(REG_GAIN_VROT, rand_extreme(16'h8000, 16'h7fff, 16));
  endtask

  initial begin
    int modes_idle[4];
    int modes_stall[4];
    cycles = 0;
    idle_pct = 0;
    stall_pct = 0;
    cur_dz = 0;
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    out_tready = 1'b1;
    cfg_we = 1'b0;
    cfg_index = REG_AXIS_SELECT;
    cfg_wdata = '0;
    modes_idle = '{0, 48, 0, 33};
    modes_stall = '{0, 0, 48, 33};
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    send_sample({16'hffff, 16'h7fff, 16'h8000, 16'h1234, 16'h0000, 16'h7fff, 16'h8000});
    drain();

    // Extreme gains with no dead zone, including the overflow of the most
    // negative gain against full negative deflection.
    write_reg(REG_AXIS_SELECT, 16'(0 | (1 << 3) | (2 << 6)));
    write_reg(REG_BUTTON_SELECT, 16'(0 | (15 << 5) | (16 << 10)));
    write_reg(REG_DEAD_ZONE_X, 16'h0);
    write_reg(REG_DEAD_ZONE_Y, 16'h0);
    write_reg(REG_DEAD_ZONE_ROT, 16'h0);
    write_reg(REG_GAIN_VX, 16'h8000);
    write_reg(REG_GAIN_VY, 16'h7fff);
    write_reg(REG_GAIN_VROT, 16'h8000);
    send_sample({16'hffff, {6{16'h8000}}});
    send_sample({16'h0000, {6{16'h7fff}}});
    send_sample({16'h8001, {6{16'h0000}}});
    send_sample({16'h7ffe, 48'h0, 16'h8000, 16'h7fff, 16'h8000});
    send_sample({16'h5555, 48'h0, 16'h0001, 16'h0000, 16'h0001});
    send_sample({16'haaaa, 48'h0, 16'h7fff, 16'h7fff, 16'hffff});
    send_sample({16'h0001, 48'h0, 16'h4000, 16'hc000, 16'h2000});
    drain();

    // Widest dead zone on rot, x and y past the last input, kick and activate buttons out of range.
    write_reg(REG_AXIS_SELECT, 16'(6 | (7 << 3) | (5 << 6)));
    write_reg(REG_BUTTON_SELECT, 16'(31 | (16 << 5) | (0 << 10)));
    write_reg(REG_DEAD_ZONE_ROT, 16'h7fff);
    write_reg(REG_GAIN_VROT, 16'h7fff);
    send_sample({16'hffff, 16'h7fff, {5{16'h8000}}});
    send_sample({16'h0000, 16'h8000, {5{16'h7fff}}});
    send_sample({16'h0001, 16'h8001, {5{16'h1111}}});
    send_sample({16'hfffe, 16'h7ffe, {5{16'h2222}}});
    drain();

    // Dead zone edges on x and y.
    write_reg(REG_AXIS_SELECT, 16'(3 | (4 << 3) | (0 << 6)));
    write_reg(REG_DEAD_ZONE_X, 16'h1000);
    write_reg(REG_DEAD_ZONE_Y, 16'h7fff);
    write_reg(REG_GAIN_VX, 16'h7fff);
    write_reg(REG_GAIN_VY, 16'h8000);
    send_sample({16'h0, 16'h0, 16'h7fff, 16'h1000, 48'h0});
    send_sample({16'h0, 16'h0, 16'h8001, 16'h0fff, 48'h0});
    send_sample({16'h0, 16'h0, 16'h8000, 16'hf000, 48'h0});
    send_sample({16'h0, 16'h0, 16'h7ffe, 16'h8000, 48'h0});
    send_sample({16'h0, 16'h0, 16'h4000, 16'h1001, 48'h0});
    drain();

    for (int p = 0; p < 8; p++) begin
      random_setting();
      idle_pct = modes_idle[p % 4];
      stall_pct = modes_stall[p % 4];
      for (int n = 0; n < 175; n++) send_sample(rand_sample());
      drain();
      idle_pct = 0;
      stall_pct = 0;
    end

    $display("covered %0d results over directed extremes and eight random settings,",
             results_seen);
    $display("with sender gaps and receiver stalls in four mixes");
    if (fail_count == 0 && pending == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("%0d mismatches, %0d results missing", fail_count, pending);
      $display("CHECKS FAILED");
    end
    $finish;
  end
endmodule
